>>> rtl/core/bfba_pkg.sv
// ----------------------------------------------------------------------------
// bfba_pkg: shared types for the best-fit block allocator
// Item and result payloads, the search token that walks the cell chain and
// the per-cell command group.
// ----------------------------------------------------------------------------
package bfba_pkg;

  localparam int SIZE_W  = 16;
  localparam int PIDX_W  = 7;
  localparam int LIMIT_W = 8;

  // item kinds
  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [PIDX_W-1:0] partition_index;
    logic [SIZE_W-1:0] amount;
  } item_t;

  typedef struct packed {
    logic              found;
    logic [PIDX_W-1:0] granted_index;
  } result_t;

  // search token; best index travels beside it at the chain's own width
  typedef struct packed {
    logic              valid;
    logic              have;
    logic [SIZE_W-1:0] amount;
    logic [SIZE_W-1:0] best_size;
  } token_t;

  // write commands decoded for one cell
  typedef struct packed {
    logic load;
    logic grant;
  } cell_cmd_t;

endpackage

>>> rtl/core/bfba_cell.sv
// ----------------------------------------------------------------------------
// bfba_cell: one partition of the allocator chain
// Holds a partition size and its allocated mark, and updates the passing
// search token with this partition when it is a better fit.
// ----------------------------------------------------------------------------
module bfba_cell #(
  parameter int IDX   = 0,
  parameter int IDX_W = 7
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [bfba_pkg::LIMIT_W-1:0]   blocks_in_use,
  input  bfba_pkg::cell_cmd_t            cmd,
  input  logic [bfba_pkg::SIZE_W-1:0]    load_size,
  input  bfba_pkg::token_t               tok_in,
  input  logic [IDX_W-1:0]               idx_in,
  output bfba_pkg::token_t               tok_out,
  output logic [IDX_W-1:0]               idx_out
);
  import bfba_pkg::*;

  logic [SIZE_W-1:0] size;
  logic              taken;
  logic              in_search;
  logic              better;

  // partition storage
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      size <= load_size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      taken <= 1'b0;
    end else if (cmd.load) begin
      taken <= 1'b0;
    end else if (cmd.grant) begin
      taken <= 1'b1;
    end
  end

  // compare against the best fit so far
  assign in_search = {24'd0, blocks_in_use} > 32'(IDX);
  assign better    = in_search && !taken && (size >= tok_in.amount) &&
                     (!tok_in.have || (size < tok_in.best_size));

  // token stage: valid is control, the rest is payload
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    tok_out.amount <= tok_in.amount;
    if (better) begin
      tok_out.have      <= 1'b1;
      tok_out.best_size <= size;
      idx_out           <= IDX_W'(IDX);
    end else begin
      tok_out.have      <= tok_in.have;
      tok_out.best_size <= tok_in.best_size;
      idx_out           <= idx_in;
    end
  end

endmodule

>>> rtl/core/best_fit_block_allocator_core.sv
// ----------------------------------------------------------------------------
// best_fit_block_allocator_core: best-fit partition allocator
// Keeps PARTITIONS partition sizes with allocated marks in a row of cells and
// grants the smallest free fitting partition of the first blocks_in_use.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid / item_stall / item): a load item writes one
//   partition size and frees it and gives no result.
//   A request item starts a search token that moves one cell per cycle down
//   the chain; the result register loads when the token leaves the last
//   cell, and the result can then be taken.
//   A new request is taken only after the previous search has left the
//   chain; loads can follow each other every cycle while item_stall is low.
//   result channel (result_valid / result_stall / result): one result per
//   request, held in an output register. item_stall is high during a search
//   and while a result waits with result_stall high, so no item is taken
//   until a stalled result has been accepted.
//   cfg channel (cfg_valid / cfg_ready / cfg_data): writes blocks_in_use;
//   always ready, write only while idle.
//   Reset clears all allocated marks and blocks_in_use; sizes are undefined
//   until loaded.
// ----------------------------------------------------------------------------
module best_fit_block_allocator_core #(
  parameter int PARTITIONS = 128
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  bfba_pkg::item_t                  item,
  output logic                             result_valid,
  input  logic                             result_stall,
  output bfba_pkg::result_t                result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bfba_pkg::LIMIT_W-1:0]     cfg_data
);
  import bfba_pkg::*;

  localparam int IDX_W = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;

  logic [LIMIT_W-1:0] blocks_in_use;
  logic               scanning;
  logic               item_accept;
  logic               req_accept;
  token_t             tok [0:PARTITIONS];
  logic [IDX_W-1:0]   tok_idx [0:PARTITIONS];
  cell_cmd_t          cmd [0:PARTITIONS-1];
  logic [31:0]        tail_idx_wide;

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      blocks_in_use <= '0;
    end else if (cfg_valid && cfg_ready) begin
      blocks_in_use <= cfg_data;
    end
  end

  // input handshake
  assign item_stall  = scanning || (result_valid && result_stall);
  assign item_accept = item_valid && !item_stall;
  assign req_accept  = item_accept && (item.kind == KIND_REQUEST);

  // token entering the head of the chain
  assign tok[0]     = '{valid: req_accept, have: 1'b0, amount: item.amount,
                        best_size: '0};
  assign tok_idx[0] = '0;

  // search in flight until the token leaves the last cell
  always_ff @(posedge clk) begin
    if (rst) begin
      scanning <= 1'b0;
    end else if (req_accept) begin
      scanning <= 1'b1;
    end else if (tok[PARTITIONS].valid) begin
      scanning <= 1'b0;
    end
  end

  // cell chain with load and grant decode
  for (genvar i = 0; i < PARTITIONS; i++) begin : g_cell
    assign cmd[i] = '{
      load:  item_accept && (item.kind == KIND_LOAD) &&
             (32'(item.partition_index) == 32'(i)),
      grant: tok[PARTITIONS].valid && tok[PARTITIONS].have &&
             (32'(tok_idx[PARTITIONS]) == 32'(i))
    };

    bfba_cell #(
      .IDX   (i),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .blocks_in_use (blocks_in_use),
      .cmd           (cmd[i]),
      .load_size     (item.amount),
      .tok_in        (tok[i]),
      .idx_in        (tok_idx[i]),
      .tok_out       (tok[i+1]),
      .idx_out       (tok_idx[i+1])
    );
  end

  // result register
  assign tail_idx_wide = 32'(tok_idx[PARTITIONS]);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (tok[PARTITIONS].valid) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tok[PARTITIONS].valid) begin
      result.found         <= tok[PARTITIONS].have;
      result.granted_index <= tok[PARTITIONS].have ? tail_idx_wide[PIDX_W-1:0] : '0;
    end
  end

  // checks
  a_req_starts_scan: assert property (@(posedge clk) disable iff (rst)
    req_accept |=> scanning)
    else $error("request accepted without a search in flight");

  a_tail_ends_scan: assert property (@(posedge clk) disable iff (rst)
    tok[PARTITIONS].valid |=> !scanning)
    else $error("search still marked busy after the token left the chain");

  a_tail_in_scan: assert property (@(posedge clk) disable iff (rst)
    tok[PARTITIONS].valid |-> scanning)
    else $error("token left the chain with no search in flight");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    tok[PARTITIONS].valid |-> !(result_valid && result_stall))
    else $error("search finished while a stalled result still waits");

  a_miss_index_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.found) |-> (result.granted_index == '0))
    else $error("result without a grant carries a nonzero index");

endmodule

>>> bench/tb_best_fit_block_allocator_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_best_fit_block_allocator_core: self-checking bench for the allocator
// Drives load and request items with random sender gaps and receiver stalls.
// Also writes blocks_in_use across its range, and checks every grant against
// a best-fit predictor that keeps its own partition table.
// ----------------------------------------------------------------------------
module tb_best_fit_block_allocator_core;
  import bfba_pkg::*;

  localparam int PARTITIONS     = 128;
  localparam int SETTLE_CYCLES  = PARTITIONS + 4;
  localparam int ITEMS_PER_PASS = 75;
  localparam int CYCLE_LIMIT    = 2_000_000;
  localparam int MAX_REPORTS    = 10;

  // directed table: either a blocks_in_use write or one item
  typedef enum logic {ROW_CFG, ROW_ITEM} row_op_e;

  typedef struct packed {
    row_op_e             op;
    logic [LIMIT_W-1:0]  cfg;
    logic                kind;
    logic [PIDX_W-1:0]   idx;
    logic [SIZE_W-1:0]   amount;
    logic                typed;
    logic                exp_found;
    logic [PIDX_W-1:0]   exp_idx;
  } dir_row_t;

  localparam int DIR_ROWS = 23;

  // op, cfg, kind, index, amount, typed expectation, found, index
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{ROW_CFG,  8'd0, KIND_LOAD,    7'd0,   16'h0000, 1'b0, 1'b0, 7'd0},
    // nothing searched with a zero count
    '{ROW_ITEM, 8'd0, KIND_REQUEST, 7'd0,   16'h0000, 1'b1, 1'b0, 7'd0},
    '{ROW_ITEM, 8'd0, KIND_LOAD,    7'd0,   16'hFFFF, 1'b0, 1'b0, 7'd0},
    '{ROW_ITEM, 8'd0, KIND_LOAD,    7'd1,   16'h0000, 1'b0, 1'b0, 7'd0},
    '{ROW_ITEM, 8'd0, KIND_LOAD,    7'd2,   16'h0064, 1'b0, 1'b0, 7'd0},
    '{ROW_ITEM, 8'd0, KIND_LOAD,    7'd3,   16'h0064, 1'b0, 1'b0, 7'd0},
    '{ROW_ITEM, 8'd0, KIND_LOAD,    7'd127, 16'h0032, 1'b0, 1'b0, 7'd0},
    '{ROW_ITEM, 8'd0, KIND_REQUEST, 7'd127, 16'hFFFF, 1'b1, 1'b0, 7'd0},
    '{ROW_CFG,  8'd4, KIND_LOAD,    7'd0,   16'h0000, 1'b0, 1'b0, 7'd0},
    // largest request only fits partition 0
    '{ROW_ITEM, 8'd0, KIND_REQUEST, 7'd0,   16'hFFFF, 1'b1, 1'b1, 7'd0},
    // zero request takes the zero-sized partition
    '{ROW_ITEM, 8'd0, KIND_REQUEST, 7'd0,   16'h0000, 1'b1, 1'b1, 7'd1},
    // equal sizes: lowest index first
    '{ROW_ITEM, 8'd0, KIND_REQUEST, 7'd55,  16'h0064, 1'b0, 1'b0, 7'd0},
    '{ROW_ITEM, 8'd0, KIND_REQUEST, 7'd0,   16'h0064, 1'b0, 1'b0, 7'd0},
    // everything taken
    '{ROW_ITEM, 8'd0, KIND_REQUEST, 7'd0,   16'h0001, 1'b1, 1'b0, 7'd0},
    // reloads free partitions
    '{ROW_ITEM, 8'd0, KIND_LOAD,    7'd1,   16'h0005, 1'b0, 1'b0, 7'd0},
    '{ROW_ITEM, 8'd0, KIND_LOAD,    7'd0,   16'hFFFF, 1'b0, 1'b0, 7'd0},
    '{ROW_ITEM, 8'd0, KIND_REQUEST, 7'd0,   16'h0003, 1'b0, 1'b0, 7'd0},
    '{ROW_ITEM, 8'd0, KIND_REQUEST, 7'd0,   16'h0006, 1'b0, 1'b0, 7'd0},
    '{ROW_CFG,  8'd1, KIND_LOAD,    7'd0,   16'h0000, 1'b0, 1'b0, 7'd0},
    '{ROW_ITEM, 8'd0, KIND_LOAD,    7'd0,   16'h8000, 1'b0, 1'b0, 7'd0},
    '{ROW_ITEM, 8'd0, KIND_REQUEST, 7'd0,   16'h8001, 1'b1, 1'b0, 7'd0},
    '{ROW_ITEM, 8'd0, KIND_REQUEST, 7'd0,   16'h8000, 1'b0, 1'b0, 7'd0},
    '{ROW_ITEM, 8'd0, KIND_REQUEST, 7'd0,   16'h7FFF, 1'b1, 1'b0, 7'd0}
  };

  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic               item_valid   = 1'b0;
  logic               item_stall;
  item_t              item         = '0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  result_t            result;
  logic               cfg_valid    = 1'b0;
  logic               cfg_ready;
  logic [LIMIT_W-1:0] cfg_data     = '0;

  // predictor state
  logic [SIZE_W-1:0]  size_table [PARTITIONS];
  bit                 taken_mark [PARTITIONS];
  int unsigned        search_count;

  result_t            expected_grants [$];
  int unsigned        mismatches     = 0;
  int unsigned        cycle_count    = 0;
  int unsigned        send_idle_pct  = 0;
  int unsigned        recv_idle_pct  = 0;

  best_fit_block_allocator_core #(
    .PARTITIONS (PARTITIONS)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // best fit over the searched partitions; loads write a size and free it
  function automatic void predict_grant(input item_t it, output bit has_result,
                                        output result_t grant);
    int unsigned span;
    int unsigned best;
    bit          hit;
    has_result = 1'b0;
    grant      = '0;
    if (it.kind == KIND_LOAD) begin
      size_table[it.partition_index] = it.amount;
      taken_mark[it.partition_index] = 1'b0;
      return;
    end
    span = (search_count > PARTITIONS) ? PARTITIONS : search_count;
    hit  = 1'b0;
    best = 0;
    for (int unsigned i = 0; i < span; i++) begin
      if (!taken_mark[i] && size_table[i] >= it.amount &&
          (!hit || size_table[i] < size_table[best])) begin
        best = i;
        hit  = 1'b1;
      end
    end
    has_result = 1'b1;
    if (hit) begin
      taken_mark[best]    = 1'b1;
      grant.found         = 1'b1;
      grant.granted_index = PIDX_W'(best);
    end
  endfunction

  // sizes with ties, extremes and full-width values
  function automatic logic [SIZE_W-1:0] pick_amount();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10)
      return (r < 5) ? '0 : '1;
    else if (r < 45)
      return SIZE_W'($urandom_range(15)) << 8;
    else if (r < 75)
      return SIZE_W'($urandom_range(4095));
    return SIZE_W'($urandom);
  endfunction

  // offer one item, hold it until taken, then predict its result
  task automatic send_item(input item_t it, input bit typed, input result_t typed_grant);
    bit      has_result;
    result_t grant;
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    predict_grant(it, has_result, grant);
    if (has_result)
      expected_grants.push_back(typed ? typed_grant : grant);
  endtask

  // blocks_in_use is only written with the block idle
  task automatic write_blocks(input logic [LIMIT_W-1:0] value);
    item_valid <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid    <= 1'b0;
    search_count = value;
  endtask

  // receiver stalls
  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // result checker
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_grants.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: found %0b index %0d", result.found,
                   result.granted_index);
      end else begin
        want = expected_grants.pop_front();
        if (result.found !== want.found || result.granted_index !== want.granted_index) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("grant mismatch: expected found %0b index %0d, got found %0b index %0d",
                     want.found, want.granted_index, result.found, result.granted_index);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** best_fit_block_allocator_core: FAILED **");
      $finish;
    end
  end

  initial begin
    item_t              it;
    result_t            typed_grant;
    int unsigned        span;
    int unsigned        send_plan [3];
    int unsigned        recv_plan [3];
    logic [LIMIT_W-1:0] count_plan [6];

    send_plan = '{23, 71, 0};
    recv_plan = '{71, 23, 0};
    for (int i = 0; i < PARTITIONS; i++) begin
      size_table[i] = '0;
      taken_mark[i] = 1'b0;
    end
    search_count = 0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed table
    send_idle_pct = send_plan[0];
    recv_idle_pct = recv_plan[0];
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (DIR_TABLE[r].op == ROW_CFG) begin
        write_blocks(DIR_TABLE[r].cfg);
      end else begin
        it.kind                   = DIR_TABLE[r].kind;
        it.partition_index        = DIR_TABLE[r].idx;
        it.amount                 = DIR_TABLE[r].amount;
        typed_grant.found         = DIR_TABLE[r].exp_found;
        typed_grant.granted_index = DIR_TABLE[r].exp_idx;
        send_item(it, DIR_TABLE[r].typed, typed_grant);
      end
    end

    // load every partition so that any search count stays on written sizes
    for (int i = 0; i < PARTITIONS; i++) begin
      it.kind            = KIND_LOAD;
      it.partition_index = PIDX_W'(i);
      it.amount          = pick_amount();
      send_item(it, 1'b0, '0);
    end

    // random passes: three idle mixes, each over several search counts
    for (int m = 0; m < 3; m++) begin
      send_idle_pct = send_plan[m];
      recv_idle_pct = recv_plan[m];
      count_plan = '{8'd128, 8'd255, 8'd1, LIMIT_W'($urandom_range(2, 127)), 8'd129, 8'd0};
      for (int p = 0; p < 6; p++) begin
        write_blocks(count_plan[p]);
        span = (search_count > PARTITIONS) ? PARTITIONS : search_count;
        for (int n = 0; n < ITEMS_PER_PASS; n++) begin
          // now and then hold off until the block has drained
          if ($urandom_range(99) == 0 && expected_grants.size() != 0) begin
            item_valid <= 1'b0;
            while (expected_grants.size() != 0) @(posedge clk);
          end
          it.kind   = ($urandom_range(99) < 35) ? KIND_LOAD : KIND_REQUEST;
          it.amount = pick_amount();
          if (span > 0 && $urandom_range(99) < 70)
            it.partition_index = PIDX_W'($urandom_range(span - 1));
          else
            it.partition_index = PIDX_W'($urandom);
          // exact size of a searched partition gives ties and tight fits
          if (it.kind == KIND_REQUEST && span > 0 && $urandom_range(99) < 30)
            it.amount = size_table[$urandom_range(span - 1)];
          send_item(it, 1'b0, '0);
        end
      end
    end

    // drain and let the last search finish
    item_valid <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_grants.size() == 0)
      $display("** best_fit_block_allocator_core: PASSED **");
    else
      $display("** best_fit_block_allocator_core: FAILED **");
    $finish;
  end

endmodule
